>>> rtl/core/lmfls_pkg.sv
// Shared types and constants for the LED matrix frame loader and row scanner.
// Used by the front, back and top modules under rtl/core; depends on nothing.
package lmfls_pkg;

  // Default sizes of the display
  localparam int FRAME_BYTES_DEF   = 512;
  localparam int ROWS_DEF          = 16;
  localparam int BYTES_PER_ROW_DEF = 32;

  // Address width wide enough for the largest store or scan range
  localparam int CMD_AW = 12;

  // Queue depths between the parts
  localparam int CMD_DEPTH = 2;
  localparam int OUT_DEPTH = 4;

  // Load header: upper nibble 0xA, low bit selects dim mode
  localparam logic [7:0] HDR_MASK = 8'hF0;
  localparam logic [7:0] HDR_CODE = 8'hA0;

  // Work handed from the front to the back: a store write or a row scan
  typedef struct packed {
    logic              tick;
    logic [CMD_AW-1:0] addr;
    logic [7:0]        data;
    logic              dim;
    logic [3:0]        sel;
  } cmd_t;

  // One result item
  typedef struct packed {
    logic [7:0] shift_byte;
    logic [3:0] row_select;
    logic       blank_while_shifting;
    logic       latch_now;
  } res_t;

endpackage

>>> rtl/core/lmfls_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module lmfls_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/core/lmfls_fifo.sv
// Small register FIFO with valid/ready on both sides.
// No dependencies; DEPTH must be a power of two.
module lmfls_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [WIDTH-1:0] in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [WIDTH-1:0] out_data
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [NW-1:0]    count;
  logic             push;
  logic             pop;

  assign in_ready  = (count != NW'(DEPTH));
  assign out_valid = (count != '0);
  assign out_data  = mem[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + NW'(push) - NW'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= in_data;
    end
  end

endmodule

>>> rtl/core/lmfls_front.sv
// Front part: accepts serial bytes and row ticks, tracks load and row state,
// and turns them into store writes and row scans. Depends on lmfls_pkg.
module lmfls_front import lmfls_pkg::*; #(
  parameter int FRAME_BYTES   = FRAME_BYTES_DEF,
  parameter int ROWS          = ROWS_DEF,
  parameter int BYTES_PER_ROW = BYTES_PER_ROW_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       req_type,
  input  logic [7:0] rx_byte,
  output logic       cmd_valid,
  input  logic       cmd_ready,
  output cmd_t       cmd
);

  localparam int SAW = $clog2(FRAME_BYTES);
  localparam int RW  = $clog2(ROWS);
  localparam logic [SAW-1:0]    LAST_COUNT = SAW'(FRAME_BYTES - 1);
  localparam logic [RW-1:0]     LAST_ROW   = RW'(ROWS - 1);
  localparam logic [6:0]        ROWS_M1    = 7'(ROWS - 1);
  localparam logic [CMD_AW-1:0] BPR_C      = CMD_AW'(BYTES_PER_ROW);

  logic           loading;
  logic [SAW-1:0] load_count;
  logic           dim_mode;
  logic [RW-1:0]  scan_row;
  logic           accept;
  logic           header;

  assign in_ready  = cmd_ready;
  assign accept    = in_valid && in_ready;
  assign header    = ((rx_byte & HDR_MASK) == HDR_CODE);
  // idle non-header bytes are taken and dropped
  assign cmd_valid = in_valid && (req_type || loading);

  always_comb begin
    cmd.tick = req_type;
    cmd.addr = req_type ? CMD_AW'(scan_row) * BPR_C : CMD_AW'(load_count);
    cmd.data = rx_byte;
    cmd.dim  = dim_mode;
    cmd.sel  = 4'(ROWS_M1 - 7'(scan_row));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      loading    <= 1'b0;
      load_count <= '0;
      dim_mode   <= 1'b0;
      scan_row   <= '0;
    end else if (accept) begin
      if (req_type) begin
        scan_row <= (scan_row == LAST_ROW) ? '0 : scan_row + 1'b1;
      end else if (loading) begin
        load_count <= load_count + 1'b1;
        if (load_count == LAST_COUNT) begin
          loading <= 1'b0;
        end
      end else if (header) begin
        dim_mode   <= rx_byte[0];
        loading    <= 1'b1;
        load_count <= '0;
      end
    end
  end

endmodule

>>> rtl/core/lmfls_back.sv
// Back part: executes store writes and row scans against the frame store,
// reading one byte per cycle under output credits. Depends on lmfls_pkg, lmfls_ram.
module lmfls_back import lmfls_pkg::*; #(
  parameter int FRAME_BYTES   = FRAME_BYTES_DEF,
  parameter int BYTES_PER_ROW = BYTES_PER_ROW_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic cmd_valid,
  output logic cmd_ready,
  input  cmd_t cmd,
  output logic res_valid,
  output res_t res,
  input  logic res_pop
);

  localparam int SAW = $clog2(FRAME_BYTES);
  localparam int FW  = $clog2(FRAME_BYTES + 1);
  localparam int CW  = (BYTES_PER_ROW > 1) ? $clog2(BYTES_PER_ROW) : 1;
  localparam int KW  = $clog2(OUT_DEPTH + 1);
  localparam int XW  = CMD_AW + 1;

  typedef enum logic {ST_IDLE, ST_SCAN} state_t;

  state_t            state;
  logic [CW-1:0]     col;
  logic [CMD_AW-1:0] base;
  logic [3:0]        sel;
  logic              dim;
  logic [FW-1:0]     fill;
  logic [KW-1:0]     credits;
  logic              rv;
  logic              r_zero;
  logic              r_last;
  logic [3:0]        r_sel;
  logic              r_dim;

  logic              take;
  logic              we;
  logic              issue;
  logic [CMD_AW-1:0] raddr;
  logic [XW-1:0]     wfill;
  logic              miss;
  logic [7:0]        rdata;

  assign cmd_ready = (state == ST_IDLE);
  assign take      = cmd_valid && cmd_ready;
  assign we        = take && !cmd.tick;
  // hold the read until a slot in the result queue is reserved
  assign issue     = (state == ST_SCAN) && (credits != '0);
  assign raddr     = base + CMD_AW'(col);
  assign wfill     = XW'(cmd.addr) + 1'b1;
  // the store is written as a prefix from address zero; beyond it reads as zero
  assign miss      = (XW'(raddr) >= XW'(fill));

  lmfls_ram #(
    .WIDTH (8),
    .DEPTH (FRAME_BYTES)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (SAW'(cmd.addr)),
    .wdata (cmd.data),
    .re    (issue),
    .raddr (SAW'(raddr)),
    .rdata (rdata)
  );

  assign res_valid                = rv;
  assign res.shift_byte           = ~(r_zero ? 8'h00 : rdata);
  assign res.row_select           = r_sel;
  assign res.blank_while_shifting = r_dim;
  assign res.latch_now            = r_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      fill    <= '0;
      credits <= KW'(OUT_DEPTH);
      rv      <= 1'b0;
    end else begin
      rv      <= issue;
      credits <= credits + KW'(res_pop) - KW'(issue);
      case (state)
        ST_IDLE: begin
          if (take) begin
            if (cmd.tick) begin
              base  <= cmd.addr;
              sel   <= cmd.sel;
              dim   <= cmd.dim;
              col   <= CW'(BYTES_PER_ROW - 1);
              state <= ST_SCAN;
            end else if (wfill > XW'(fill)) begin
              fill <= FW'(wfill);
            end
          end
        end
        ST_SCAN: begin
          if (issue) begin
            r_zero <= miss;
            r_last <= (col == '0);
            r_sel  <= sel;
            r_dim  <= dim;
            if (col == '0) begin
              state <= ST_IDLE;
            end else begin
              col <= col - 1'b1;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_credit_bound: assert property (@(posedge clk) disable iff (rst)
    credits <= KW'(OUT_DEPTH))
    else $error("result credits exceed queue depth");

  a_write_fills: assert property (@(posedge clk) disable iff (rst)
    we |=> (fill != '0))
    else $error("store write did not extend the fill count");

  a_scan_ends: assert property (@(posedge clk) disable iff (rst)
    (issue && (col == '0)) |=> (state == ST_IDLE) && rv && r_last)
    else $error("row scan did not end on the latch byte");

endmodule

>>> rtl/core/led_matrix_frame_loader_and_scanner_top.sv
// Throughput: a row tick occupies the scan unit until its last byte is read, one
// frame store read per cycle while result credits remain; serial bytes are taken
// one per cycle while the command queue has room.
// Reset: control state clears at once; a fill count makes unwritten store bytes
// read as zero, so no clearing pass is needed. Depends on lmfls_pkg and submodules.
module led_matrix_frame_loader_and_scanner_top import lmfls_pkg::*; #(
  parameter int FRAME_BYTES   = FRAME_BYTES_DEF,
  parameter int ROWS          = ROWS_DEF,
  parameter int BYTES_PER_ROW = BYTES_PER_ROW_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       req_type,
  input  logic [7:0] rx_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] shift_byte,
  output logic [3:0] row_select,
  output logic       blank_while_shifting,
  output logic       latch_now
);

  logic cmd_in_valid;
  logic cmd_in_ready;
  cmd_t cmd_in;
  logic cmd_out_valid;
  logic cmd_out_ready;
  cmd_t cmd_out;
  logic res_valid;
  logic res_ready;
  res_t res;
  res_t res_out;
  logic res_pop;

  lmfls_front #(
    .FRAME_BYTES   (FRAME_BYTES),
    .ROWS          (ROWS),
    .BYTES_PER_ROW (BYTES_PER_ROW)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .req_type  (req_type),
    .rx_byte   (rx_byte),
    .cmd_valid (cmd_in_valid),
    .cmd_ready (cmd_in_ready),
    .cmd       (cmd_in)
  );

  lmfls_fifo #(
    .WIDTH ($bits(cmd_t)),
    .DEPTH (CMD_DEPTH)
  ) u_cmd_q (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (cmd_in_valid),
    .in_ready  (cmd_in_ready),
    .in_data   (cmd_in),
    .out_valid (cmd_out_valid),
    .out_ready (cmd_out_ready),
    .out_data  (cmd_out)
  );

  lmfls_back #(
    .FRAME_BYTES   (FRAME_BYTES),
    .BYTES_PER_ROW (BYTES_PER_ROW)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_out_valid),
    .cmd_ready (cmd_out_ready),
    .cmd       (cmd_out),
    .res_valid (res_valid),
    .res       (res),
    .res_pop   (res_pop)
  );

  lmfls_fifo #(
    .WIDTH ($bits(res_t)),
    .DEPTH (OUT_DEPTH)
  ) u_res_q (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (res_valid),
    .in_ready  (res_ready),
    .in_data   (res),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (res_out)
  );

  assign res_pop              = out_valid && out_ready;
  assign shift_byte           = res_out.shift_byte;
  assign row_select           = res_out.row_select;
  assign blank_while_shifting = res_out.blank_while_shifting;
  assign latch_now            = res_out.latch_now;

  a_res_room: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> res_ready)
    else $error("result arrived with the result queue full");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid && $stable(shift_byte) && $stable(latch_now))
    else $error("waiting result changed before it was taken");

endmodule
